@@ hw/rtl/dvsd_pkg.sv @@
// shared types and constants for the differential volume stream decoder
`timescale 1ns / 1ps

package dvsd_pkg;

	localparam int STRIP_LENGTH_BITS_DEF = 16;

	localparam int BUF_BITS       = 32;
	localparam int FILL_BITS      = 6;
	localparam int BYTE_BITS      = 8;
	localparam int FILL_LIMIT     = 24;
	localparam int DIST_BITS      = 2;
	localparam int CNT_BITS       = 7;
	localparam int WC_BITS        = 3;
	localparam int CHUNK_HDR_BITS = CNT_BITS + WC_BITS;
	localparam int CW_BITS        = 4;
	localparam int OUT_DIST_BITS  = 3;

	typedef enum logic [1:0] {
		PH_STREAM_HDR,
		PH_CHUNK_HDR,
		PH_SAMPLES,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic                 byte_valid;
		logic [BYTE_BITS-1:0] stream_byte;
	} in_word_t;

	typedef struct packed {
		logic                     byte_taken;
		logic                     sample_valid;
		logic [BYTE_BITS-1:0]     sample;
		logic                     finished;
		logic [OUT_DIST_BITS-1:0] interleave_distance;
	} out_word_t;

endpackage

@@ hw/rtl/differential_volume_stream_decoder_top.sv @@
// path: a word is registered in word_s1, its result word in word_s2
// throughput: one input word and one result word per cycle while out_ready
//   holds, set by the single decode step and the prefetched history ring read
// reset: arst_n clears the pipeline valids and all decoder control state;
//   the history ring has no reset and is never read before it is written
`timescale 1ns / 1ps

module differential_volume_stream_decoder_top
	import dvsd_pkg::*;
#(
	parameter int STRIP_LENGTH_BITS = STRIP_LENGTH_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	logic      valid_s1, valid_s2;
	in_word_t  word_s1;
	out_word_t word_s2;
	out_word_t result;
	logic      advance;

	logic                         ring_we;
	logic [STRIP_LENGTH_BITS-1:0] ring_waddr, ring_raddr;
	logic [BYTE_BITS-1:0]         ring_wdata, ring_rdata;

	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = valid_s2;
	assign out_data  = word_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= in_data;
		end
		if (advance) begin
			word_s2 <= result;
		end
	end

	dvsd_core #(
		.STRIP_LENGTH_BITS(STRIP_LENGTH_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (advance),
		.in_word    (word_s1),
		.result     (result),
		.ring_we    (ring_we),
		.ring_waddr (ring_waddr),
		.ring_wdata (ring_wdata),
		.ring_raddr (ring_raddr),
		.ring_rdata (ring_rdata)
	);

	dvsd_ring #(
		.ADDR_BITS(STRIP_LENGTH_BITS)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with empty result register");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("result word without an input word");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while waiting");

endmodule

@@ hw/rtl/dvsd_ring.sv @@
// increment history ring: one write and one registered read per cycle
`timescale 1ns / 1ps

module dvsd_ring
	import dvsd_pkg::*;
#(
	parameter int ADDR_BITS = STRIP_LENGTH_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [BYTE_BITS-1:0] wdata,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [BYTE_BITS-1:0] rdata
);

	localparam int DEPTH = 1 << ADDR_BITS;

	logic [BYTE_BITS-1:0] mem [DEPTH];
	logic [BYTE_BITS-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// a read of the entry written in the same cycle sees the new value
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rd_q <= wdata;
		end else begin
			rd_q <= mem[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

@@ hw/rtl/dvsd_core.sv @@
// decoder state and single-step decode of one input word
`timescale 1ns / 1ps

module dvsd_core
	import dvsd_pkg::*;
#(
	parameter int STRIP_LENGTH_BITS = STRIP_LENGTH_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  in_word_t                     in_word,
	output out_word_t                    result,
	output logic                         ring_we,
	output logic [STRIP_LENGTH_BITS-1:0] ring_waddr,
	output logic [BYTE_BITS-1:0]         ring_wdata,
	output logic [STRIP_LENGTH_BITS-1:0] ring_raddr,
	input  logic [BYTE_BITS-1:0]         ring_rdata
);

	localparam int SLB  = STRIP_LENGTH_BITS;
	localparam int SLW  = SLB + 1;
	localparam logic [FILL_BITS-1:0] HDR_N   = FILL_BITS'(DIST_BITS + SLB);
	localparam logic [FILL_BITS-1:0] CHUNK_N = FILL_BITS'(CHUNK_HDR_BITS);
	localparam logic [FILL_BITS-1:0] BYTE_N  = FILL_BITS'(BYTE_BITS);
	localparam logic [FILL_BITS-1:0] LIMIT_N = FILL_BITS'(FILL_LIMIT);

	phase_t                   phase_q, phase_d;
	logic [BUF_BITS-1:0]      buf_q, buf_d, buf_a;
	logic [FILL_BITS-1:0]     fill_q, fill_d, fill_a, take_n, shamt;
	logic [OUT_DIST_BITS-1:0] dist_q, dist_d;
	logic [SLW-1:0]           strip_q, strip_d;
	logic [CNT_BITS-1:0]      left_q, left_d;
	logic [CW_BITS-1:0]       cw_q, cw_d;
	logic [BYTE_BITS-1:0]     rv_q, rv_d;
	logic [SLW-1:0]           prod_q, prod_d;
	logic [SLB-1:0]           pos_q, pos_d;

	logic                     taken;
	logic [BUF_BITS-1:0]      ext;
	logic [BYTE_BITS-1:0]     code, half, v, hist;
	logic                     svalid;

	always_comb begin
		taken = go && in_word.byte_valid && (phase_q != PH_DONE) && (fill_q <= LIMIT_N);
		buf_a  = taken ? {buf_q[BUF_BITS-BYTE_BITS-1:0], in_word.stream_byte} : buf_q;
		fill_a = taken ? fill_q + BYTE_N : fill_q;

		case (phase_q)
			PH_STREAM_HDR: take_n = HDR_N;
			PH_CHUNK_HDR:  take_n = CHUNK_N;
			PH_SAMPLES:    take_n = FILL_BITS'(cw_q);
			default:       take_n = '0;
		endcase
		shamt = fill_a - take_n;
		ext   = buf_a >> shamt;

		// sample arithmetic, used only in the sample phase
		code = ext[BYTE_BITS-1:0] & BYTE_BITS'((9'd1 << cw_q) - 9'd1);
		half = (cw_q == '0) ? '0 : BYTE_BITS'(9'd1 << (cw_q - 4'd1));
		hist = (prod_q > strip_q) ? ring_rdata : '0;
		v    = rv_q + code - half + hist;

		phase_d = phase_q;
		buf_d   = buf_a;
		fill_d  = fill_a;
		dist_d  = dist_q;
		strip_d = strip_q;
		left_d  = left_q;
		cw_d    = cw_q;
		rv_d    = rv_q;
		prod_d  = prod_q;
		pos_d   = pos_q;
		svalid  = 1'b0;

		if (go) begin
			case (phase_q)
				PH_STREAM_HDR: begin
					if (fill_a >= HDR_N) begin
						fill_d  = shamt;
						dist_d  = {1'b0, ext[SLB+DIST_BITS-1:SLB]} + OUT_DIST_BITS'(1);
						strip_d = {1'b0, ext[SLB-1:0]} + SLW'(1);
						phase_d = PH_CHUNK_HDR;
					end
				end
				PH_CHUNK_HDR: begin
					if (fill_a >= CHUNK_N) begin
						fill_d  = shamt;
						left_d  = ext[CHUNK_HDR_BITS-1:WC_BITS];
						cw_d    = (ext[WC_BITS-1:0] == '0) ? '0
						          : {1'b0, ext[WC_BITS-1:0]} + CW_BITS'(1);
						phase_d = (ext[CHUNK_HDR_BITS-1:WC_BITS] == '0) ? PH_DONE
						          : PH_SAMPLES;
					end
				end
				PH_SAMPLES: begin
					if (fill_a >= FILL_BITS'(cw_q)) begin
						fill_d = shamt;
						svalid = 1'b1;
						rv_d   = v;
						pos_d  = pos_q + SLB'(1);
						if (prod_q <= strip_q) begin
							prod_d = prod_q + SLW'(1);
						end
						left_d = left_q - CNT_BITS'(1);
						if (left_q == CNT_BITS'(1)) begin
							phase_d = PH_CHUNK_HDR;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign ring_we    = svalid;
	assign ring_waddr = pos_q;
	assign ring_wdata = v - rv_q;
	// prefetch the history entry that the next sample will need
	assign ring_raddr = pos_d - strip_d[SLB-1:0];

	always_comb begin
		result.byte_taken          = taken;
		result.sample_valid        = svalid;
		result.sample              = svalid ? v : '0;
		result.finished            = (phase_d == PH_DONE);
		result.interleave_distance = dist_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_STREAM_HDR;
			buf_q   <= '0;
			fill_q  <= '0;
			dist_q  <= OUT_DIST_BITS'(1);
			strip_q <= SLW'(1);
			left_q  <= '0;
			cw_q    <= '0;
			rv_q    <= '0;
			prod_q  <= '0;
			pos_q   <= '0;
		end else begin
			phase_q <= phase_d;
			buf_q   <= buf_d;
			fill_q  <= fill_d;
			dist_q  <= dist_d;
			strip_q <= strip_d;
			left_q  <= left_d;
			cw_q    <= cw_d;
			rv_q    <= rv_d;
			prod_q  <= prod_d;
			pos_q   <= pos_d;
		end
	end

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) |=> (phase_q == PH_DONE))
		else $error("decoder left the done phase");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_BITS'(BUF_BITS))
		else $error("bit buffer overfilled");

	a_prod_bound: assert property (@(posedge clk) disable iff (!arst_n)
		prod_q <= strip_q + SLW'(1))
		else $error("produced count past saturation");

endmodule
